// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

// ante at one edge implies cons at the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

  localparam int DEF_MAX_WINDOW = 16;
  localparam int DEF_SEQ_BITS   = 16;

  localparam int WIN_W     = 5;
  localparam int TOTAL_W   = 16;
  localparam int TIMEOUT_W = 24;
  localparam int ACK_W     = 16;
  localparam int SEQ_OUT_W = 16;
  localparam int EV_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic [WIN_W-1:0]     RST_WINDOW  = WIN_W'(4);
  localparam logic [TOTAL_W-1:0]   RST_TOTAL   = TOTAL_W'(10);
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = TIMEOUT_W'(1000);
  localparam logic [TIMEOUT_W-1:0] TICK_MAX    = '1;

  localparam logic KIND_SEND   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 2'd0,
    EV_ADVANCE = 2'd1,
    EV_DUP     = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_TOTAL   = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_PLAN,
    S_SEND,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic plan;
    logic step;
    logic status;
  } ctl_cmd_t;

  typedef struct packed {
    logic send_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/gbn_in_if.sv
`default_nettype none

interface gbn_in_if;
  import gbn_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [ACK_W-1:0] ack_seq;

  modport source (output valid, mode, ack_seq, input ready);
  modport sink (input valid, mode, ack_seq, output ready);
endinterface

`default_nettype wire

// File: design/gbn_out_if.sv
`default_nettype none

interface gbn_out_if;
  import gbn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [SEQ_OUT_W-1:0] seq_out;
  logic [EV_W-1:0]      event_res;
  logic [SEQ_OUT_W-1:0] window_base;
  logic                 done_res;
  logic                 last;

  modport source (output valid, kind, seq_out, event_res, window_base, done_res, last,
                  input ready);
  modport sink (input valid, kind, seq_out, event_res, window_base, done_res, last,
                output ready);
endinterface

`default_nettype wire

// File: design/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  gbn_pkg::dp_stat_t stat,
  output gbn_pkg::ctl_cmd_t cmd
);
  import gbn_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_UPDATE;
      end
      S_UPDATE: state_next = S_PLAN;
      S_PLAN:   state_next = S_SEND;
      S_SEND: begin
        if (!stat.send_ok) state_next = S_STATUS;
      end
      S_STATUS: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_PLAN:   cmd.plan = 1'b1;
      S_SEND: begin
        out_valid = stat.send_ok;
        cmd.step  = stat.send_ok && out_ready;
      end
      S_STATUS: begin
        out_valid  = 1'b1;
        cmd.status = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: design/gbn_dp.sv
`default_nettype none

module gbn_dp #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW,
  parameter int SEQ_BITS   = gbn_pkg::DEF_SEQ_BITS
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [gbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [gbn_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  wire                              in_mode,
  input  wire  [gbn_pkg::ACK_W-1:0]        in_ack_seq,
  input  gbn_pkg::ctl_cmd_t                cmd,
  output gbn_pkg::dp_stat_t                stat,
  output logic                             out_kind,
  output logic [gbn_pkg::SEQ_OUT_W-1:0]    out_seq_out,
  output logic [gbn_pkg::EV_W-1:0]         out_event_res,
  output logic [gbn_pkg::SEQ_OUT_W-1:0]    out_window_base,
  output logic                             out_done_res,
  output logic                             out_last
);
  import gbn_pkg::*;

  localparam int SB = SEQ_BITS;
  localparam int CW = ((SEQ_BITS > ACK_W) ? SEQ_BITS : ACK_W) + 1;
  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int WW = (NW > WIN_W) ? NW : WIN_W;

  logic [WIN_W-1:0]     win_cfg;
  logic [TOTAL_W-1:0]   total_cfg;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  logic [SB-1:0]        base_seq, base_seq_next;
  logic [SB-1:0]        next_seq, next_seq_next;
  logic [TIMEOUT_W-1:0] idle_ticks, idle_ticks_next;
  ev_t                  ev, ev_next;

  logic                 mode;
  logic [ACK_W-1:0]     ack_seq;
  logic [CW-1:0]        limit;
  logic                 done;
  logic [NW-1:0]        cnt;

  logic [CW-1:0]        ack_ext, base_ext, total_ext, cand_full, cand_clip;
  logic [SB-1:0]        cand;
  logic [TIMEOUT_W-1:0] idle_inc, tick_lim;
  logic [WW-1:0]        win_eff;
  logic [CW-1:0]        limit_sum;

  assign ack_ext   = CW'(ack_seq);
  assign base_ext  = CW'(base_seq);
  assign total_ext = CW'(total_cfg);
  assign cand_full = ack_ext + CW'(1);
  assign cand_clip = (cand_full > total_ext) ? total_ext : cand_full;
  assign cand      = cand_clip[SB-1:0];
  assign idle_inc  = (idle_ticks == TICK_MAX) ? idle_ticks : idle_ticks + TIMEOUT_W'(1);
  assign tick_lim  = (timeout_ticks == '0) ? TIMEOUT_W'(1) : timeout_ticks;
  assign win_eff   = (WW'(win_cfg) > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW)
                                                      : WW'(win_cfg);
  assign limit_sum = base_ext + CW'(win_eff);

  // protocol state update for one accepted item
  always_comb begin
    base_seq_next   = base_seq;
    next_seq_next   = next_seq;
    idle_ticks_next = idle_ticks;
    ev_next         = EV_NONE;
    if (mode) begin
      idle_ticks_next = '0;
      if (ack_ext >= base_ext) begin
        if (CW'(cand) > base_ext) begin
          base_seq_next = cand;
          ev_next       = EV_ADVANCE;
        end
      end else begin
        ev_next = EV_DUP;
      end
      if (next_seq < base_seq_next) next_seq_next = base_seq_next;
    end else if (base_ext < total_ext) begin
      if (idle_inc >= tick_lim) begin
        next_seq_next   = base_seq;
        idle_ticks_next = '0;
        ev_next         = EV_TIMEOUT;
      end else begin
        idle_ticks_next = idle_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg       <= RST_WINDOW;
      total_cfg     <= RST_TOTAL;
      timeout_ticks <= RST_TIMEOUT;
      base_seq      <= '0;
      next_seq      <= '0;
      idle_ticks    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW:  win_cfg       <= cfg_data[WIN_W-1:0];
          CFG_TOTAL:   total_cfg     <= cfg_data[TOTAL_W-1:0];
          CFG_TIMEOUT: timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        base_seq   <= base_seq_next;
        next_seq   <= next_seq_next;
        idle_ticks <= idle_ticks_next;
      end else if (cmd.step) begin
        next_seq <= next_seq + SB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode    <= in_mode;
      ack_seq <= in_ack_seq;
    end
    if (cmd.update) ev <= ev_next;
    if (cmd.plan) begin
      done  <= (base_ext >= total_ext);
      limit <= (limit_sum > total_ext) ? total_ext : limit_sum;
      cnt   <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + NW'(1);
    end
  end

  assign stat.send_ok = (CW'(next_seq) < limit) && (cnt < NW'(MAX_WINDOW));

  assign out_kind        = cmd.status ? KIND_STATUS : KIND_SEND;
  assign out_seq_out     = SEQ_OUT_W'(next_seq);
  assign out_event_res   = ev;
  assign out_window_base = SEQ_OUT_W'(base_seq);
  assign out_done_res    = done;
  assign out_last        = cmd.status;

endmodule

`default_nettype wire

// File: design/go_back_n_sender_window.sv
// Accepts one item, then updates the protocol state (S_UPDATE) and plans the window (S_PLAN).
// Sends leave one per cycle while the sink is ready, up to MAX_WINDOW of them,
// then the controller leaves S_SEND for S_STATUS and the status item follows.
// Synchronous rst: window 4, total 10, timeout 1000; base, next and idle count cleared.
`default_nettype none

`include "assert_macros.svh"

module go_back_n_sender_window #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW,
  parameter int SEQ_BITS   = gbn_pkg::DEF_SEQ_BITS
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire  [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [gbn_pkg::CFG_DAT_W-1:0] cfg_data,
  gbn_in_if.sink                        evt,
  gbn_out_if.source                     res
);
  import gbn_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (evt.valid),
    .in_ready  (evt.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbn_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_mode         (evt.mode),
    .in_ack_seq      (evt.ack_seq),
    .cmd             (cmd),
    .stat            (stat),
    .out_kind        (res.kind),
    .out_seq_out     (res.seq_out),
    .out_event_res   (res.event_res),
    .out_window_base (res.window_base),
    .out_done_res    (res.done_res),
    .out_last        (res.last)
  );

  `ASSERT_NEVER(a_no_overlap, clk, rst, evt.ready && res.valid)
  `ASSERT_NEXT(a_accept_quiet, clk, rst, evt.valid && evt.ready, !res.valid && !evt.ready)
  `ASSERT_NEXT(a_status_ends, clk, rst, res.valid && res.ready && res.last, evt.ready)

endmodule

`default_nettype wire

// File: test/go_back_n_sender_window_tb.sv
`default_nettype none

module go_back_n_sender_window_tb;
  import gbn_pkg::*;

  localparam int WMAX = DEF_MAX_WINDOW;

  typedef struct packed {
    logic                 kind;
    logic [SEQ_OUT_W-1:0] seq;
    logic [EV_W-1:0]      ev;
    logic [SEQ_OUT_W-1:0] base;
    logic                 done;
    logic                 last;
  } tx_result_t;

  class send_plan_checker;
    logic [WIN_W-1:0]     win_reg = RST_WINDOW;
    logic [TOTAL_W-1:0]   total_reg = RST_TOTAL;
    logic [TIMEOUT_W-1:0] tmo_reg = RST_TIMEOUT;
    logic [SEQ_OUT_W-1:0] base = '0;
    logic [SEQ_OUT_W-1:0] next_tx = '0;
    logic [TIMEOUT_W-1:0] idle_cnt = '0;
    tx_result_t           planned[$];
    int                   mismatches = 0;

    function void write_reg(cfg_idx_t idx, int unsigned val);
      case (idx)
        CFG_WINDOW:  win_reg = WIN_W'(val);
        CFG_TOTAL:   total_reg = TOTAL_W'(val);
        CFG_TIMEOUT: tmo_reg = TIMEOUT_W'(val);
        default: ;
      endcase
    endfunction

    function void push(logic kind, logic [SEQ_OUT_W-1:0] seq, ev_t ev, logic done);
      tx_result_t r;
      r.kind = kind;
      r.seq  = seq;
      r.ev   = ev;
      r.base = base;
      r.done = done;
      r.last = (kind == KIND_STATUS);
      planned.push_back(r);
    endfunction

    function void note_event(logic mode, logic [ACK_W-1:0] ack);
      int unsigned win_eff, lim, limit, n;
      logic [ACK_W:0] cand;
      ev_t ev;
      logic done;
      ev = EV_NONE;
      win_eff = (win_reg > WMAX) ? WMAX : win_reg;
      if (mode) begin
        idle_cnt = '0;
        if (ack >= base) begin
          cand = {1'b0, ack} + 1'b1;
          if (cand > total_reg) cand = {1'b0, total_reg};
          if (cand[SEQ_OUT_W-1:0] > base) begin
            base = cand[SEQ_OUT_W-1:0];
            ev = EV_ADVANCE;
          end
        end else begin
          ev = EV_DUP;
        end
        if (next_tx < base) next_tx = base;
      end else if (base < total_reg) begin
        lim = (tmo_reg == 0) ? 1 : tmo_reg;
        if (idle_cnt < TICK_MAX) idle_cnt = idle_cnt + 1'b1;
        if (idle_cnt >= lim) begin
          next_tx = base;
          idle_cnt = '0;
          ev = EV_TIMEOUT;
        end
      end
      done = (base >= total_reg);
      limit = base + win_eff;
      if (limit > total_reg) limit = total_reg;
      n = 0;
      while (next_tx < limit && n < WMAX) begin
        push(KIND_SEND, next_tx, ev, done);
        n++;
        next_tx = next_tx + 1'b1;
      end
      push(KIND_STATUS, next_tx, ev, done);
    endfunction

    function void same_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(tx_result_t got);
      tx_result_t exp;
      if (planned.size() == 0) begin
        $display("%0t: unexpected item, expected none got seq_out %0d", $time, got.seq);
        mismatches++;
      end else begin
        exp = planned.pop_front();
        same_field("kind", exp.kind, got.kind);
        same_field("seq_out", exp.seq, got.seq);
        same_field("event_res", exp.ev, got.ev);
        same_field("window_base", exp.base, got.base);
        same_field("done_res", exp.done, got.done);
        same_field("last", exp.last, got.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 steady = 1'b0;
  logic                 hold_req = 1'b0;

  gbn_in_if  evt_if();
  gbn_out_if res_if();

  send_plan_checker sb = new;

  go_back_n_sender_window u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_if.sink),
    .res       (res_if.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (evt_if.valid && evt_if.ready) sb.note_event(evt_if.mode, evt_if.ack_seq);
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.kind, res_if.seq_out, res_if.event_res,
                         res_if.window_base, res_if.done_res, res_if.last});
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (steady) begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        res_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (300) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic offer(input logic m, input logic [ACK_W-1:0] a);
    evt_if.valid   <= 1'b1;
    evt_if.mode    <= m;
    evt_if.ack_seq <= a;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
  endtask

  task automatic maybe_idle(input int rate);
    if (!steady && rate != 0 && $urandom_range(1, 4) <= rate) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    evt_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.planned.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned tot,
                            input int unsigned tmo);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_data  <= CFG_DAT_W'(w);
    @(posedge clk);
    cfg_index <= CFG_TOTAL;
    cfg_data  <= CFG_DAT_W'(tot);
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= CFG_DAT_W'(tmo);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_WINDOW, w);
    sb.write_reg(CFG_TOTAL, tot);
    sb.write_reg(CFG_TIMEOUT, tmo);
  endtask

  // mostly acks near the window, some ticks, a few arbitrary items
  task automatic random_item();
    int d, a;
    if ($urandom_range(0, 11) == 0) begin
      offer(1'($urandom_range(0, 1)), ACK_W'($urandom_range(0, 65535)));
    end else if ($urandom_range(0, 9) < 4) begin
      offer(1'b0, ACK_W'($urandom));
    end else begin
      if (sb.base != 0 && $urandom_range(0, 5) == 0) begin
        d = $urandom_range(1, 3);
        a = int'(sb.base) - d;
      end else begin
        d = $urandom_range(0, int'(sb.next_tx) - int'(sb.base) + 2);
        a = int'(sb.base) + d - 1;
      end
      if (a < 0) a = 0;
      if (a > 65535) a = 65535;
      offer(1'b1, ACK_W'(a));
    end
  endtask

  initial begin
    #1000000;
    $display("FAIL go_back_n_sender_window");
    $finish;
  end

  initial begin
    int unsigned w, tot, tmo;
    int rate;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_WINDOW;
    cfg_data       <= '0;
    evt_if.valid   <= 1'b0;
    evt_if.mode    <= 1'b0;
    evt_if.ack_seq <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first sends, advance, duplicate, ack past next
    offer(1'b0, 16'hFFFF);
    maybe_idle(2);
    offer(1'b1, 16'd0);
    offer(1'b1, 16'd0);
    maybe_idle(2);
    offer(1'b1, 16'd6);
    // zero timeout, zero window
    set_config(0, 10, 0);
    offer(1'b0, 16'd0);
    // oversized window, ack beyond the total, activity after done
    set_config(31, 100, 1);
    offer(1'b0, 16'd0);
    offer(1'b1, 16'd7);
    maybe_idle(2);
    offer(1'b1, 16'hFFFF);
    offer(1'b0, 16'h5555);
    offer(1'b1, 16'd50);
    offer(1'b1, 16'd100);
    // total below base
    set_config(16, 50, 2);
    offer(1'b0, 16'hAAAA);
    offer(1'b1, 16'd99);
    set_config(1, 130, 3);
    offer(1'b0, 16'd0);
    offer(1'b0, 16'd0);
    maybe_idle(2);
    offer(1'b0, 16'd0);

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 7))
        0: w = 1;
        1: w = 16;
        2: w = 0;
        3: w = 31;
        default: w = $urandom_range(2, 15);
      endcase
      tot = int'(sb.base) + $urandom_range(15, 60);
      tmo = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      if (ph == 2) w = 16;
      set_config(w, tot, tmo);
      rate = (ph == 2) ? 0 : $urandom_range(0, 3);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < 13; k++) begin
        if (ph == 3 && k == 8) drain();
        random_item();
        maybe_idle(rate);
      end
    end

    steady = 1'b1;
    set_config(16, 65535, 24'hFFFFFF);
    repeat (6) random_item();
    offer(1'b1, 16'd65533);
    offer(1'b0, 16'd0);
    offer(1'b1, 16'd65535);
    offer(1'b0, 16'hFFFF);
    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.planned.size() == 0) begin
      $display("PASS go_back_n_sender_window");
    end else begin
      $display("FAIL go_back_n_sender_window");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/gbn_pkg.sv
design/gbn_in_if.sv
design/gbn_out_if.sv
design/gbn_ctrl.sv
design/gbn_dp.sv
design/go_back_n_sender_window.sv
test/go_back_n_sender_window_tb.sv
